FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

	typedef logic [3:0] kind_t;

	localparam kind_t KIND_NUM    = 4'd0;
	localparam kind_t KIND_IDENT  = 4'd1;
	localparam kind_t KIND_BRACE  = 4'd2;
	localparam kind_t KIND_PAREN  = 4'd3;
	localparam kind_t KIND_ASSIGN = 4'd4;
	localparam kind_t KIND_LE     = 4'd5;
	localparam kind_t KIND_NE     = 4'd6;
	localparam kind_t KIND_GE     = 4'd7;
	localparam kind_t KIND_END    = 4'd8;
	localparam kind_t KIND_ERR    = 4'd9;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [9:0] {
		M_IDLE  = 10'b00_0000_0001,
		M_NUM   = 10'b00_0000_0010,
		M_IDENT = 10'b00_0000_0100,
		M_BRACE = 10'b00_0000_1000,
		M_POPEN = 10'b00_0001_0000,
		M_PBODY = 10'b00_0010_0000,
		M_PSTAR = 10'b00_0100_0000,
		M_COLON = 10'b00_1000_0000,
		M_LT    = 10'b01_0000_0000,
		M_GT    = 10'b10_0000_0000
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		kind_t token_kind;
		logic  run_last;
	} out_word_t;

	// one queue entry holds all tokens of one input word
	typedef struct packed {
		logic  two;
		kind_t k0;
		kind_t k1;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_port_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

FILE: rtl/pascal_like_token_scanner.sv
`timescale 1ns / 1ps
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    in_data  (ch, end_of_text)
// out      out  out_valid / out_ready  out_data (token_kind, run_last)
//
// one character word accepted per clock; in_ready drops only while the token queue is full
// tokens go via the queue and output register, one token per clock while out_ready is high
// a word with two tokens holds its queue entry until both have been loaded for output
// asynchronous reset returns the scanner to idle, not halted, with queue and output empty
// an output stall fills the queue (QUEUE_DEPTH entries) before the input is held off
module pascal_like_token_scanner #(
	parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pts_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pts_pkg::out_word_t out_data
);
	import pts_pkg::*;

	q_port_t push, head;
	logic    full, pop, take;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	pts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (in_data),
		.push   (push)
	);

	pts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	pts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/pts_front.sv
`timescale 1ns / 1ps
module pts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  pts_pkg::in_word_t word,
	output pts_pkg::q_port_t  push
);
	import pts_pkg::*;

	typedef struct packed {
		mode_t mode;
		logic  end_mark;
		logic  fail;
	} start_t;

	mode_t mode_q, mode_d;
	logic  halted_q, halted_d;

	logic  a_v, b_v, c_v;
	kind_t a_k, b_k, c_k;
	start_t st;

	function automatic start_t start_fn(input logic [7:0] c);
		start_t r;
		r = '{mode: M_IDLE, end_mark: 1'b0, fail: 1'b0};
		if (is_digit(c)) r.mode = M_NUM;
		else if (is_alpha(c)) r.mode = M_IDENT;
		else if (c == CH_LBRACE) r.mode = M_BRACE;
		else if (c == CH_LPAREN) r.mode = M_POPEN;
		else if (c == CH_COLON) r.mode = M_COLON;
		else if (c == CH_LT) r.mode = M_LT;
		else if (c == CH_GT) r.mode = M_GT;
		else if (c == CH_DOLLAR) r.end_mark = 1'b1;
		else if (!is_space(c)) r.fail = 1'b1;
		return r;
	endfunction

	assign st = start_fn(word.ch);

	// a: token closed by this char, b: what starting on this char gives, c: flush at end
	always_comb begin
		mode_d   = mode_q;
		halted_d = halted_q;
		a_v = 1'b0; a_k = KIND_NUM;
		b_v = 1'b0; b_k = KIND_END;
		c_v = 1'b0; c_k = KIND_ERR;
		if (!halted_q) begin
			unique case (mode_q)
				M_NUM: begin
					if (!is_digit(word.ch)) begin
						a_v = 1'b1; a_k = KIND_NUM;
					end
				end
				M_IDENT: begin
					if (!is_digit(word.ch) && !is_alpha(word.ch)) begin
						a_v = 1'b1; a_k = KIND_IDENT;
					end
				end
				M_BRACE: begin
					if (word.ch == CH_RBRACE) begin
						a_v = 1'b1; a_k = KIND_BRACE; mode_d = M_IDLE;
					end
				end
				M_POPEN: begin
					if (word.ch == CH_STAR) mode_d = M_PBODY;
					else begin
						a_v = 1'b1; a_k = KIND_ERR; mode_d = M_IDLE; halted_d = 1'b1;
					end
				end
				M_PBODY: begin
					if (word.ch == CH_STAR) mode_d = M_PSTAR;
				end
				M_PSTAR: begin
					if (word.ch == CH_RPAREN) begin
						a_v = 1'b1; a_k = KIND_PAREN; mode_d = M_IDLE;
					end else if (word.ch != CH_STAR) begin
						mode_d = M_PBODY;
					end
				end
				M_COLON: begin
					a_v = 1'b1; mode_d = M_IDLE;
					if (word.ch == CH_EQUAL) a_k = KIND_ASSIGN;
					else begin
						a_k = KIND_ERR; halted_d = 1'b1;
					end
				end
				M_LT: begin
					a_v = 1'b1; mode_d = M_IDLE;
					if (word.ch == CH_EQUAL) a_k = KIND_LE;
					else if (word.ch == CH_GT) a_k = KIND_NE;
					else begin
						a_k = KIND_ERR; halted_d = 1'b1;
					end
				end
				M_GT: begin
					a_v = 1'b1; mode_d = M_IDLE;
					if (word.ch == CH_EQUAL) a_k = KIND_GE;
					else begin
						a_k = KIND_ERR; halted_d = 1'b1;
					end
				end
				default: ;
			endcase
			// idle, an unknown mode, or a number or identifier just ended: scan this char as a fresh start
			if ((mode_q == M_IDLE) || (((mode_q == M_NUM) || (mode_q == M_IDENT)) && a_v)
			    || ((mode_q != M_NUM) && (mode_q != M_IDENT) && (mode_q != M_BRACE)
			        && (mode_q != M_POPEN) && (mode_q != M_PBODY) && (mode_q != M_PSTAR)
			        && (mode_q != M_COLON) && (mode_q != M_LT) && (mode_q != M_GT))) begin
				mode_d = st.mode;
				if (st.end_mark) begin
					b_v = 1'b1; b_k = KIND_END;
				end
				if (st.fail) begin
					b_v = 1'b1; b_k = KIND_ERR; mode_d = M_IDLE; halted_d = 1'b1;
				end
			end
		end
		if (word.end_of_text) begin
			if (!halted_d) begin
				if (mode_d == M_NUM) begin
					c_v = 1'b1; c_k = KIND_NUM;
				end else if (mode_d == M_IDENT) begin
					c_v = 1'b1; c_k = KIND_IDENT;
				end else if (mode_d != M_IDLE) begin
					c_v = 1'b1; c_k = KIND_ERR;
				end
			end
			mode_d   = M_IDLE;
			halted_d = 1'b0;
		end
	end

	// pack up to two tokens in order
	always_comb begin
		push.valid     = take && (a_v || b_v || c_v);
		push.entry.two = 1'b0;
		push.entry.k0  = c_k;
		push.entry.k1  = c_k;
		if (a_v) begin
			push.entry.k0 = a_k;
			if (b_v) begin
				push.entry.two = 1'b1; push.entry.k1 = b_k;
			end else if (c_v) begin
				push.entry.two = 1'b1; push.entry.k1 = c_k;
			end
		end else if (b_v) begin
			push.entry.k0 = b_k;
			if (c_v) begin
				push.entry.two = 1'b1; push.entry.k1 = c_k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			halted_q <= 1'b0;
		end else if (take) begin
			mode_q   <= mode_d;
			halted_q <= halted_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (mode_q == M_IDLE))
		else $error("halted scanner left in a token mode");
`endif

endmodule

FILE: rtl/pts_queue.sv
`timescale 1ns / 1ps
module pts_queue #(
	parameter int DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pts_pkg::q_port_t push,
	output logic             full,
	output pts_pkg::q_port_t head,
	input  logic             pop
);
	import pts_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t            mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push.valid) mem[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push.valid && !pop) count_q <= count_q + 1'b1;
			else if (!push.valid && pop) count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("word pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/pts_back.sv
`timescale 1ns / 1ps
module pts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::q_port_t   head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output pts_pkg::out_word_t out_data
);
	import pts_pkg::*;

	logic      out_valid_q;
	out_word_t out_q;
	logic      phase_q;
	logic      load;

	assign load      = head.valid && (!out_valid_q || out_ready);
	// second token of a pair, or the only one, finishes the entry
	assign pop       = load && (phase_q || !head.entry.two);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.token_kind <= phase_q ? head.entry.k1 : head.entry.k0;
			out_q.run_last   <= phase_q || !head.entry.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (load) phase_q <= !pop;
		end
	end

`ifndef NO_ASSERTIONS
	a_phase_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head.valid && head.entry.two))
		else $error("second-token phase without a pair at queue head");
`endif

endmodule
